/* rtl/core/tcc_pkg.sv */
// Shared types and widths for the triangle circumcircle pipeline.
package tcc_pkg;

	// Quotient bits the divider resolves; the center clamps at 2^40.
	localparam int QBITS = 41;
	// Divider numerator, denominator and remainder widths.
	localparam int NUM_W = 101;
	localparam int DEN_W = 67;
	localparam int DIV_W = DEN_W + QBITS;
	// Root bits of the square root and its remainder width.
	localparam int ROOT_W = 32;
	localparam int REM_W  = ROOT_W + 4;

	localparam logic [QBITS-1:0] QLIM = {1'b1, {(QBITS-1){1'b0}}};

	typedef struct packed {
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p2_x;
		logic signed [31:0] p2_y;
		logic signed [31:0] p3_x;
		logic signed [31:0] p3_y;
	} tcc_in_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [31:0]        circle_radius;
		logic               collinear;
		logic               overflowed;
	} tcc_out_t;

endpackage

/* rtl/core/tcc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module tcc_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tcc_pkg::NUM_W-1:0]     num,
	input  logic [tcc_pkg::DEN_W-1:0]     den,
	output logic [tcc_pkg::QBITS-1:0]     quo
);

	localparam int QB = tcc_pkg::QBITS;
	localparam int DW = tcc_pkg::DIV_W;

	logic [DW-1:0]                 rem_s [0:QB-1];
	logic [tcc_pkg::DEN_W-1:0]     den_s [0:QB-1];
	logic [QB-1:0]                 quo_s [0:QB-1];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			logic [DW-1:0]             rin;
			logic [tcc_pkg::DEN_W-1:0] din;
			logic [QB-1:0]             qin;
			logic [DW-1:0]             dsh;

			if (k == 0) begin : g_first
				assign rin = DW'(num);
				assign din = den;
				assign qin = '0;
			end else begin : g_rest
				assign rin = rem_s[k-1];
				assign din = den_s[k-1];
				assign qin = quo_s[k-1];
			end

			// trial subtract of the divisor aligned to this bit
			assign dsh = DW'(din) << (QB - 1 - k);

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= din;
					if (rin >= dsh) begin
						rem_s[k] <= rin - dsh;
						quo_s[k] <= {qin[QB-2:0], 1'b1};
					end else begin
						rem_s[k] <= rin;
						quo_s[k] <= {qin[QB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign quo = quo_s[QB-1];

endmodule

/* rtl/core/tcc_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module tcc_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [2*tcc_pkg::ROOT_W-1:0]   sq,
	output logic [tcc_pkg::ROOT_W-1:0]     root,
	output logic [tcc_pkg::REM_W-1:0]      rem
);

	localparam int RB = tcc_pkg::ROOT_W;
	localparam int RW = tcc_pkg::REM_W;
	localparam int SW = 2 * RB;

	logic [RW-1:0] rem_s  [0:RB-1];
	logic [RB-1:0] root_s [0:RB-1];
	logic [SW-1:0] sq_s   [0:RB-1];

	genvar k;
	generate
		for (k = 0; k < RB; k++) begin : g_stage
			logic [RW-1:0] rin;
			logic [RB-1:0] tin;
			logic [SW-1:0] sin;
			logic [RW-1:0] cur;
			logic [RW-1:0] trial;

			if (k == 0) begin : g_first
				assign rin = '0;
				assign tin = '0;
				assign sin = sq;
			end else begin : g_rest
				assign rin = rem_s[k-1];
				assign tin = root_s[k-1];
				assign sin = sq_s[k-1];
			end

			// bring down the next two radicand bits, try 4*root+1
			assign cur   = {rin[RW-3:0], sin[SW-1:SW-2]};
			assign trial = RW'({tin, 2'b01});

			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[k] <= {sin[SW-3:0], 2'b00};
					if (cur >= trial) begin
						rem_s[k]  <= cur - trial;
						root_s[k] <= {tin[RB-2:0], 1'b1};
					end else begin
						rem_s[k]  <= cur;
						root_s[k] <= {tin[RB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign root = root_s[RB-1];
	assign rem  = rem_s[RB-1];

endmodule

/* rtl/core/tcc_outq.sv */
// Two-entry output queue that decouples the pipeline from the result port.
module tcc_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcc_pkg::tcc_out_t push_word,
	output logic              space,
	output logic              valid,
	input  logic              ready,
	output tcc_pkg::tcc_out_t word
);

	logic [1:0]        cnt_q;
	tcc_pkg::tcc_out_t head_q;
	tcc_pkg::tcc_out_t tail_q;
	logic              pop;

	assign pop   = valid && ready;
	assign valid = (cnt_q != 2'd0);
	assign space = (cnt_q != 2'd2);
	assign word  = head_q;

	// track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// hold words; advance tail into head on a pop
	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_word;
			end else begin
				tail_q <= push_word;
			end
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				head_q <= push_word;
			end else begin
				head_q <= tail_q;
				tail_q <= push_word;
			end
		end
	end

endmodule

/* rtl/core/triangle_circumcircle_core.sv */
// Triangle circumcircle pipeline: perpendicular bisectors, Cramer division, radius root.
//
//   port group   dir   handshake               word
//   pts          in    pts_valid / pts_ready   tcc_in_t  (three Q16.16 vertices)
//   circ         out   circ_valid / circ_ready tcc_out_t (center, radius, flags)
//
// One word enters per cycle unless the output queue is full; the pipeline holds the 41-stage divider
// and the 32-stage square root, plus the product and sum stages around them.
// Reset clears only the valid bits and the output queue count.
// All stages advance together; a two-entry output queue keeps taking words while
// one result waits, and the pipeline freezes only when both entries are full.
module triangle_circumcircle_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pts_valid,
	output logic              pts_ready,
	input  tcc_pkg::tcc_in_t  pts,
	output logic              circ_valid,
	input  logic              circ_ready,
	output tcc_pkg::tcc_out_t circ
);

	localparam int QB = tcc_pkg::QBITS;
	localparam int RB = tcc_pkg::ROOT_W;

	typedef struct packed {
		logic               zero;
		logic               negx;
		logic               negy;
		logic               ovfx;
		logic               ovfy;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
	} div_side_t;

	typedef struct packed {
		logic               zero;
		logic               big;
		logic signed [41:0] cx;
		logic signed [41:0] cy;
	} sqrt_side_t;

	logic en;

	// stage 1: edge deltas and coordinate sums
	logic               v_s1;
	logic signed [32:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [32:0] ax1_s1, ay1_s1, ax2_s1, ay2_s1;
	logic signed [31:0] x1_s1, y1_s1;

	// stage 2: 33x33 products
	logic               v_s2;
	logic signed [65:0] pc1x_s2, pc1y_s2, pc2x_s2, pc2y_s2, pd1_s2, pd2_s2;
	logic signed [32:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2;
	logic signed [31:0] x1_s2, y1_s2;

	// stage 3: bisector constants and determinant
	logic               v_s3, zero_s3;
	logic signed [66:0] c1_s3, c2_s3, det_s3;
	logic signed [32:0] dx1_s3, dy1_s3, dx2_s3, dy2_s3;
	logic signed [31:0] x1_s3, y1_s3;

	// stage 4: partial products of deltas times split constants
	logic               v_s4, zero_s4;
	logic signed [67:0] ady2l_s4, bdy1l_s4, cdx1l_s4, ddx2l_s4;
	logic signed [65:0] ady2h_s4, bdy1h_s4, cdx1h_s4, ddx2h_s4;
	logic signed [66:0] det_s4;
	logic signed [31:0] x1_s4, y1_s4;

	// stage 5: full products
	logic                v_s5, zero_s5;
	logic signed [100:0] fa_s5, fb_s5, fc_s5, fd_s5;
	logic signed [66:0]  det_s5;
	logic signed [31:0]  x1_s5, y1_s5;

	// stage 6: numerators
	logic                v_s6, zero_s6;
	logic signed [100:0] nx_s6, ny_s6;
	logic signed [66:0]  det_s6;
	logic signed [31:0]  x1_s6, y1_s6;

	// stage 7: magnitudes and quotient signs
	logic                v_s7, zero_s7, negx_s7, negy_s7;
	logic [100:0]        mnx_s7, mny_s7;
	logic [65:0]         md_s7;
	logic signed [31:0]  x1_s7, y1_s7;

	// stage 8: rounding-biased numerators and divisor
	logic                       v_s8, zero_s8, negx_s8, negy_s8;
	logic [tcc_pkg::NUM_W-1:0]  numx_s8, numy_s8;
	logic [tcc_pkg::DEN_W-1:0]  den_s8;
	logic signed [31:0]         x1_s8, y1_s8;

	// stage 9: quotient range check
	logic                       v_s9, zero_s9, negx_s9, negy_s9, ovfx_s9, ovfy_s9;
	logic [tcc_pkg::NUM_W-1:0]  numx_s9, numy_s9;
	logic [tcc_pkg::DEN_W-1:0]  den_s9;
	logic signed [31:0]         x1_s9, y1_s9;

	// divider side channel
	logic [QB-1:0]  vd_s;
	div_side_t      sbd_s [0:QB-1];
	logic [QB-1:0]  qx, qy;

	// stages 10 to 14: center, offset, squares, sum
	logic               v_s10, zero_s10;
	logic signed [41:0] cx_s10, cy_s10;
	logic signed [31:0] x1_s10, y1_s10;

	logic               v_s11, zero_s11;
	logic signed [42:0] ex_s11, ey_s11;
	logic signed [41:0] cx_s11, cy_s11;

	logic               v_s12, zero_s12, big_s12;
	logic [31:0]        mex_s12, mey_s12;
	logic signed [41:0] cx_s12, cy_s12;

	logic               v_s13, zero_s13, big_s13;
	logic [63:0]        sqx_s13, sqy_s13;
	logic signed [41:0] cx_s13, cy_s13;

	logic               v_s14, zero_s14, big_s14;
	logic [63:0]        sum_s14;
	logic signed [41:0] cx_s14, cy_s14;

	// square root side channel
	logic [RB-1:0]            vq_s;
	sqrt_side_t               sbq_s [0:RB-1];
	logic [RB-1:0]            root;
	logic [tcc_pkg::REM_W-1:0] rem;

	// combinational helpers
	logic [QB-1:0]      mx, my;
	logic [42:0]        aex, aey;
	logic [64:0]        sum_w;
	logic [32:0]        rnd;
	logic               rad_ov, cx_hi, cx_lo, cy_hi, cy_lo;
	tcc_pkg::tcc_out_t  res;
	sqrt_side_t         sq_end;

	assign pts_ready = en;

	// valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
			vd_s  <= '0;
			vq_s  <= '0;
		end else if (en) begin
			v_s1  <= pts_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			vd_s  <= {vd_s[QB-2:0], v_s9};
			v_s10 <= vd_s[QB-1];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			vq_s  <= {vq_s[RB-2:0], v_s14};
		end
	end

	// front end: bisector setup
	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1 <= 33'(pts.p2_x) - 33'(pts.p1_x);
			dy1_s1 <= 33'(pts.p2_y) - 33'(pts.p1_y);
			dx2_s1 <= 33'(pts.p3_x) - 33'(pts.p2_x);
			dy2_s1 <= 33'(pts.p3_y) - 33'(pts.p2_y);
			ax1_s1 <= 33'(pts.p1_x) + 33'(pts.p2_x);
			ay1_s1 <= 33'(pts.p1_y) + 33'(pts.p2_y);
			ax2_s1 <= 33'(pts.p2_x) + 33'(pts.p3_x);
			ay2_s1 <= 33'(pts.p2_y) + 33'(pts.p3_y);
			x1_s1  <= pts.p1_x;
			y1_s1  <= pts.p1_y;

			pc1x_s2 <= dx1_s1 * ax1_s1;
			pc1y_s2 <= dy1_s1 * ay1_s1;
			pc2x_s2 <= dx2_s1 * ax2_s1;
			pc2y_s2 <= dy2_s1 * ay2_s1;
			pd1_s2  <= dx1_s1 * dy2_s1;
			pd2_s2  <= dx2_s1 * dy1_s1;
			dx1_s2  <= dx1_s1; dy1_s2 <= dy1_s1; dx2_s2 <= dx2_s1; dy2_s2 <= dy2_s1;
			x1_s2   <= x1_s1;  y1_s2  <= y1_s1;

			c1_s3   <= 67'(pc1x_s2) + 67'(pc1y_s2);
			c2_s3   <= 67'(pc2x_s2) + 67'(pc2y_s2);
			det_s3  <= 67'(pd1_s2) - 67'(pd2_s2);
			zero_s3 <= (pd1_s2 == pd2_s2);
			dx1_s3  <= dx1_s2; dy1_s3 <= dy1_s2; dx2_s3 <= dx2_s2; dy2_s3 <= dy2_s2;
			x1_s3   <= x1_s2;  y1_s3  <= y1_s2;

			// split each constant into a signed high and unsigned low part
			ady2l_s4 <= dy2_s3 * $signed({1'b0, c1_s3[33:0]});
			ady2h_s4 <= dy2_s3 * $signed(c1_s3[66:34]);
			bdy1l_s4 <= dy1_s3 * $signed({1'b0, c2_s3[33:0]});
			bdy1h_s4 <= dy1_s3 * $signed(c2_s3[66:34]);
			cdx1l_s4 <= dx1_s3 * $signed({1'b0, c2_s3[33:0]});
			cdx1h_s4 <= dx1_s3 * $signed(c2_s3[66:34]);
			ddx2l_s4 <= dx2_s3 * $signed({1'b0, c1_s3[33:0]});
			ddx2h_s4 <= dx2_s3 * $signed(c1_s3[66:34]);
			det_s4   <= det_s3;
			zero_s4  <= zero_s3;
			x1_s4    <= x1_s3; y1_s4 <= y1_s3;

			fa_s5   <= (101'(ady2h_s4) <<< 34) + 101'(ady2l_s4);
			fb_s5   <= (101'(bdy1h_s4) <<< 34) + 101'(bdy1l_s4);
			fc_s5   <= (101'(cdx1h_s4) <<< 34) + 101'(cdx1l_s4);
			fd_s5   <= (101'(ddx2h_s4) <<< 34) + 101'(ddx2l_s4);
			det_s5  <= det_s4;
			zero_s5 <= zero_s4;
			x1_s5   <= x1_s4; y1_s5 <= y1_s4;

			nx_s6   <= fa_s5 - fb_s5;
			ny_s6   <= fc_s5 - fd_s5;
			det_s6  <= det_s5;
			zero_s6 <= zero_s5;
			x1_s6   <= x1_s5; y1_s6 <= y1_s5;

			mnx_s7  <= nx_s6[100] ? 101'(-nx_s6) : 101'(nx_s6);
			mny_s7  <= ny_s6[100] ? 101'(-ny_s6) : 101'(ny_s6);
			md_s7   <= det_s6[66] ? 66'(-det_s6) : 66'(det_s6);
			negx_s7 <= nx_s6[100] ^ det_s6[66];
			negy_s7 <= ny_s6[100] ^ det_s6[66];
			zero_s7 <= zero_s6;
			x1_s7   <= x1_s6; y1_s7 <= y1_s6;

			// (|N| + |det|) / (2|det|) rounds |N| / (2 det) half away from zero
			numx_s8 <= mnx_s7 + tcc_pkg::NUM_W'(md_s7);
			numy_s8 <= mny_s7 + tcc_pkg::NUM_W'(md_s7);
			den_s8  <= {md_s7, 1'b0};
			negx_s8 <= negx_s7; negy_s8 <= negy_s7;
			zero_s8 <= zero_s7;
			x1_s8   <= x1_s7; y1_s8 <= y1_s7;

			ovfx_s9 <= tcc_pkg::DIV_W'(numx_s8) >= {den_s8, QB'(0)};
			ovfy_s9 <= tcc_pkg::DIV_W'(numy_s8) >= {den_s8, QB'(0)};
			numx_s9 <= numx_s8; numy_s9 <= numy_s8;
			den_s9  <= den_s8;
			negx_s9 <= negx_s8; negy_s9 <= negy_s8;
			zero_s9 <= zero_s8;
			x1_s9   <= x1_s8; y1_s9 <= y1_s8;
		end
	end

	tcc_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s9),
		.den (den_s9),
		.quo (qx)
	);

	tcc_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s9),
		.den (den_s9),
		.quo (qy)
	);

	// carry flags and first vertex alongside the dividers
	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_sbd
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (en) begin
						sbd_s[k] <= '{zero: zero_s9, negx: negx_s9, negy: negy_s9,
							ovfx: ovfx_s9, ovfy: ovfy_s9, x1: x1_s9, y1: y1_s9};
					end
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					if (en) begin
						sbd_s[k] <= sbd_s[k-1];
					end
				end
			end
		end
		for (k = 0; k < RB; k++) begin : g_sbq
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (en) begin
						sbq_s[k] <= '{zero: zero_s14, big: big_s14, cx: cx_s14, cy: cy_s14};
					end
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					if (en) begin
						sbq_s[k] <= sbq_s[k-1];
					end
				end
			end
		end
	endgenerate

	// clamp quotients, offsets from the first vertex
	always_comb begin
		mx    = (sbd_s[QB-1].ovfx || qx > tcc_pkg::QLIM) ? tcc_pkg::QLIM : qx;
		my    = (sbd_s[QB-1].ovfy || qy > tcc_pkg::QLIM) ? tcc_pkg::QLIM : qy;
		aex   = ex_s11[42] ? 43'(-ex_s11) : 43'(ex_s11);
		aey   = ey_s11[42] ? 43'(-ey_s11) : 43'(ey_s11);
		sum_w = 65'(sqx_s13) + 65'(sqy_s13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s10   <= sbd_s[QB-1].negx ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
			cy_s10   <= sbd_s[QB-1].negy ? -$signed({1'b0, my}) : $signed({1'b0, my});
			zero_s10 <= sbd_s[QB-1].zero;
			x1_s10   <= sbd_s[QB-1].x1;
			y1_s10   <= sbd_s[QB-1].y1;

			ex_s11   <= 43'(cx_s10) - 43'(x1_s10);
			ey_s11   <= 43'(cy_s10) - 43'(y1_s10);
			cx_s11   <= cx_s10; cy_s11 <= cy_s10;
			zero_s11 <= zero_s10;

			big_s12  <= (aex[42:32] != '0) || (aey[42:32] != '0);
			mex_s12  <= aex[31:0];
			mey_s12  <= aey[31:0];
			cx_s12   <= cx_s11; cy_s12 <= cy_s11;
			zero_s12 <= zero_s11;

			sqx_s13  <= mex_s12 * mex_s12;
			sqy_s13  <= mey_s12 * mey_s12;
			big_s13  <= big_s12;
			cx_s13   <= cx_s12; cy_s13 <= cy_s12;
			zero_s13 <= zero_s12;

			sum_s14  <= sum_w[63:0];
			big_s14  <= big_s13 || sum_w[64];
			cx_s14   <= cx_s13; cy_s14 <= cy_s13;
			zero_s14 <= zero_s13;
		end
	end

	tcc_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.sq   (sum_s14),
		.root (root),
		.rem  (rem)
	);

	// round the root, saturate, mask collinear results
	always_comb begin
		sq_end = sbq_s[RB-1];
		rnd    = 33'(root) + ((rem > tcc_pkg::REM_W'(root)) ? 33'd1 : 33'd0);
		rad_ov = sq_end.big || rnd[32];
		cx_hi  = sq_end.cx > 42'sd2147483647;
		cx_lo  = sq_end.cx < -42'sd2147483648;
		cy_hi  = sq_end.cy > 42'sd2147483647;
		cy_lo  = sq_end.cy < -42'sd2147483648;
		res.center_x      = cx_hi ? 32'sh7FFFFFFF : (cx_lo ? 32'sh80000000 : sq_end.cx[31:0]);
		res.center_y      = cy_hi ? 32'sh7FFFFFFF : (cy_lo ? 32'sh80000000 : sq_end.cy[31:0]);
		res.circle_radius = rad_ov ? 32'hFFFFFFFF : rnd[31:0];
		res.collinear     = 1'b0;
		res.overflowed    = rad_ov || cx_hi || cx_lo || cy_hi || cy_lo;
		if (sq_end.zero) begin
			res = '0;
			res.collinear = 1'b1;
		end
	end

	tcc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && vq_s[RB-1]),
		.push_word (res),
		.space     (en),
		.valid     (circ_valid),
		.ready     (circ_ready),
		.word      (circ)
	);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the triangle circumcircle core, with an in-bench predictor.
module tb_top;

	localparam int NUM_RANDOM  = 1450;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 200;
	localparam logic signed [127:0] SMAX = 128'sd2147483647;
	localparam logic signed [127:0] SMIN = -128'sd2147483648;
	localparam logic signed [127:0] QCLAMP = 128'sd1 << 40;
	localparam logic [127:0] R32 = 128'd1 << 32;

	logic clk;
	logic arst_n;
	logic pts_valid;
	logic pts_ready;
	tcc_pkg::tcc_in_t pts;
	logic circ_valid;
	logic circ_ready;
	tcc_pkg::tcc_out_t circ;

	tcc_pkg::tcc_in_t pending_pts[$];
	tcc_pkg::tcc_out_t expected_circ[$];
	int n_accepted;
	int n_errors;
	int idle_cycles;
	int snd_idle_pct;
	int rcv_idle_pct;

	triangle_circumcircle_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts_valid (pts_valid),
		.pts_ready (pts_ready),
		.pts       (pts),
		.circ_valid(circ_valid),
		.circ_ready(circ_ready),
		.circ      (circ)
	);

	// Rounded quotient, ties away from zero, clamped in magnitude to 2^40.
	function automatic logic signed [127:0] round_quot(logic signed [127:0] n,
			logic signed [127:0] d);
		logic neg;
		logic [127:0] mn;
		logic [127:0] md;
		logic [127:0] q;
		neg = (n < 0) != (d < 0);
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = (2 * mn + md) / (2 * md);
		if (q > QCLAMP)
			q = QCLAMP;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	// Circumcenter by bisector intersection, radius measured to the first vertex.
	function automatic tcc_pkg::tcc_out_t circumcircle(tcc_pkg::tcc_in_t p);
		logic signed [127:0] x1, y1, x2, y2, x3, y3;
		logic signed [127:0] dx1, dy1, dx2, dy2, c1, c2, det, nx, ny, cx, cy, ex, ey;
		logic [127:0] mex, mey, s, r, rem;
		logic ov;
		tcc_pkg::tcc_out_t o;
		x1 = p.p1_x; y1 = p.p1_y;
		x2 = p.p2_x; y2 = p.p2_y;
		x3 = p.p3_x; y3 = p.p3_y;
		dx1 = x2 - x1; dy1 = y2 - y1;
		dx2 = x3 - x2; dy2 = y3 - y2;
		c1 = dx1 * (x1 + x2) + dy1 * (y1 + y2);
		c2 = dx2 * (x2 + x3) + dy2 * (y2 + y3);
		det = dx1 * dy2 - dx2 * dy1;
		o = '0;
		if (det == 0) begin
			o.collinear = 1'b1;
			return o;
		end
		nx = dy2 * c1 - dy1 * c2;
		ny = dx1 * c2 - dx2 * c1;
		cx = round_quot(nx, 2 * det);
		cy = round_quot(ny, 2 * det);
		ov = 1'b0;
		ex = cx - x1;
		ey = cy - y1;
		mex = (ex < 0) ? -ex : ex;
		mey = (ey < 0) ? -ey : ey;
		s = mex * mex + mey * mey;
		if (mex >= R32 || mey >= R32 || s >= (128'd1 << 64)) begin
			o.circle_radius = '1;
			ov = 1'b1;
		end else begin
			r = '0;
			for (int i = 32; i >= 0; i--)
				if (((r | (128'd1 << i)) * (r | (128'd1 << i))) <= s)
					r = r | (128'd1 << i);
			rem = s - r * r;
			if (rem > r)
				r = r + 1;
			if (r >= R32) begin
				r = R32 - 1;
				ov = 1'b1;
			end
			o.circle_radius = r[31:0];
		end
		if (cx > SMAX) begin cx = SMAX; ov = 1'b1; end
		if (cx < SMIN) begin cx = SMIN; ov = 1'b1; end
		if (cy > SMAX) begin cy = SMAX; ov = 1'b1; end
		if (cy < SMIN) begin cy = SMIN; ov = 1'b1; end
		o.center_x = cx[31:0];
		o.center_y = cy[31:0];
		o.overflowed = ov;
		return o;
	endfunction

	function automatic logic signed [31:0] near_coord();
		return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
	endfunction

	// Random triangle: half small ones, some full range, some on a line, some with p3 beside p1.
	function automatic tcc_pkg::tcc_in_t random_triangle();
		tcc_pkg::tcc_in_t t;
		int kind;
		int k;
		kind = $urandom_range(0, 9);
		t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (kind < 5) begin
			t.p1_x = near_coord(); t.p1_y = near_coord();
			t.p2_x = near_coord(); t.p2_y = near_coord();
			t.p3_x = near_coord(); t.p3_y = near_coord();
		end else if (kind < 7) begin
			k = $urandom_range(0, 6) - 3;
			t.p1_x = near_coord(); t.p1_y = near_coord();
			t.p2_x = near_coord(); t.p2_y = near_coord();
			t.p3_x = t.p1_x + k * (t.p2_x - t.p1_x);
			t.p3_y = t.p1_y + k * (t.p2_y - t.p1_y);
		end else if (kind == 7) begin
			t.p3_x = t.p1_x + $signed($urandom_range(0, 6)) - 3;
			t.p3_y = t.p1_y + $signed($urandom_range(0, 6)) - 3;
		end
		return t;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Drive the point channel; hold each word until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_valid <= 1'b0;
			pts <= '0;
		end else begin
			if (pts_valid && pts_ready) begin
				expected_circ.push_back(circumcircle(pts));
				n_accepted <= n_accepted + 1;
			end
			if (!pts_valid || pts_ready) begin
				if (pending_pts.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					pts_valid <= 1'b1;
					pts <= pending_pts.pop_front();
				end else begin
					pts_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result word against the oldest expectation; toggle ready at random.
	always @(posedge clk or negedge arst_n) begin
		tcc_pkg::tcc_out_t exp_w;
		if (!arst_n) begin
			circ_ready <= 1'b0;
		end else begin
			circ_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			if (circ_valid && circ_ready) begin
				if (expected_circ.size() == 0) begin
					$error("unexpected result word %h", circ);
					n_errors++;
				end else begin
					exp_w = expected_circ.pop_front();
					if (circ.center_x !== exp_w.center_x) begin
						$error("center_x exp %h got %h", exp_w.center_x, circ.center_x);
						n_errors++;
					end
					if (circ.center_y !== exp_w.center_y) begin
						$error("center_y exp %h got %h", exp_w.center_y, circ.center_y);
						n_errors++;
					end
					if (circ.circle_radius !== exp_w.circle_radius) begin
						$error("circle_radius exp %h got %h", exp_w.circle_radius,
							circ.circle_radius);
						n_errors++;
					end
					if (circ.collinear !== exp_w.collinear) begin
						$error("collinear exp %b got %b", exp_w.collinear, circ.collinear);
						n_errors++;
					end
					if (circ.overflowed !== exp_w.overflowed) begin
						$error("overflowed exp %b got %b", exp_w.overflowed, circ.overflowed);
						n_errors++;
					end
				end
			end
		end
	end

	// Pick the idling mix by progress through the stimulus.
	always @(posedge clk) begin
		if (n_accepted < 500) begin
			snd_idle_pct <= 18;
			rcv_idle_pct <= 84;
		end else if (n_accepted < 1000) begin
			snd_idle_pct <= 84;
			rcv_idle_pct <= 18;
		end else begin
			snd_idle_pct <= 0;
			rcv_idle_pct <= 0;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((pts_valid && pts_ready) || (circ_valid && circ_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		tcc_pkg::tcc_in_t t;
		n_accepted = 0;
		n_errors = 0;
		idle_cycles = 0;
		snd_idle_pct = 18;
		rcv_idle_pct = 84;
		arst_n = 1'b0;

		// Directed: plain triangle, repeated points, lines, extremes, huge centers.
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536});
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
		pending_pts.push_back({32'sd5, 32'sd7, 32'sd5, 32'sd7, 32'sd9, -32'sd2});
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd2, 32'sd2});
		pending_pts.push_back({32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff});
		pending_pts.push_back({32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff});
		pending_pts.push_back({32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff});
		pending_pts.push_back({32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff});
		pending_pts.push_back({-32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd0});
		pending_pts.push_back({32'sh80000000, 32'sd0, 32'sd0, 32'sd1, 32'sh7fffffff, 32'sd0});
		pending_pts.push_back({32'sh80000000, 32'sd0, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sd1});
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sh7fffffff, 32'sd1});
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0, 32'sd4});
		pending_pts.push_back({32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1});
		pending_pts.push_back({-32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1});
		pending_pts.push_back({32'sh55555555, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'sh55555555,
			32'sh0f0f0f0f, 32'shf0f0f0f0});
		for (int i = 0; i < NUM_RANDOM; i++) begin
			t = random_triangle();
			pending_pts.push_back(t);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for all words in and all results out, then let the pipe settle.
		while (pending_pts.size() > 0 || pts_valid || expected_circ.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
